[sv/max_similarity_uncertainty_assert.svh]
// Assertion macros for the max-similarity uncertainty block.
`ifndef MAX_SIMILARITY_UNCERTAINTY_ASSERT_SVH
`define MAX_SIMILARITY_UNCERTAINTY_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define MSU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("msu check failed");

// next-cycle implication, clocked on i_clk, off during reset
`define MSU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("msu check failed");

`endif

[sv/msu_pkg.sv]
// Package: shared constants, codes and types of the max-similarity uncertainty block.
`default_nettype none
package msu_pkg;
    localparam int VAL_W      = 16;
    localparam int FIELDS     = 4;
    localparam int INV_W      = 32;
    localparam int SIM_W      = 17;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int MASK_W     = 4;
    localparam int CNT_OUT_W  = 25;
    localparam int SUM_OUT_W  = 41;
    localparam int SAMPLE_W   = VAL_W * FIELDS;

    localparam int LAYERS_DEF    = 4;
    localparam int SAMPLES_DEF   = 64;
    localparam int MAX_CELLS_DEF = 16777216;

    localparam logic [SIM_W-1:0] ONE_Q16       = 17'h10000;
    localparam logic [INV_W-1:0] INV_RESET     = 32'h0001_0000;
    localparam logic [SIM_W-1:0] THR_RESET     = 17'd13107;

    localparam logic [1:0] REQ_QUERY = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] ST_QUERY   = 2'd0;
    localparam logic [1:0] ST_STORED  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_CLEARED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_INV0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THR  = 3'd5;

    typedef struct packed {
        logic clr;
        logic vld;
    } t_merge_ctl;
endpackage
`default_nettype wire

[sv/msu_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module msu_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

[sv/msu_lane.sv]
// One layer lane: per-layer similarity of cell and sample, two register stages.
`default_nettype none
module msu_lane (
    input  logic                              i_clk,
    input  logic signed [msu_pkg::VAL_W-1:0]  i_cell,
    input  logic signed [msu_pkg::VAL_W-1:0]  i_sample,
    input  logic [msu_pkg::INV_W-1:0]         i_inv,
    input  logic                              i_eq_mode,
    output logic [msu_pkg::SIM_W-1:0]         o_sim
);
    import msu_pkg::*;

    localparam int PROD_W = VAL_W + INV_W;

    logic signed [VAL_W:0]   w_diff;
    logic [VAL_W-1:0]        w_abs;
    logic [PROD_W-1:0]       r_prod;
    logic                    r_eq;
    logic                    r_fac;
    logic [SIM_W-1:0]        w_sim;
    logic [SIM_W-1:0]        r_sim;

    assign w_diff = {i_cell[VAL_W-1], i_cell} - {i_sample[VAL_W-1], i_sample};
    always_comb begin
        logic signed [VAL_W:0] neg;
        neg = -w_diff;
        w_abs = w_diff[VAL_W] ? neg[VAL_W-1:0] : w_diff[VAL_W-1:0];
    end

    always_comb begin
        if (r_fac) begin
            w_sim = r_eq ? ONE_Q16 : '0;
        end else if (|r_prod[PROD_W-1:2*VAL_W]) begin
            w_sim = '0;
        end else begin
            w_sim = ONE_Q16 - {1'b0, r_prod[2*VAL_W-1:VAL_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(w_abs) * PROD_W'(i_inv);
        r_eq   <= (i_cell == i_sample);
        r_fac  <= i_eq_mode;
        r_sim  <= w_sim;
    end

    assign o_sim = r_sim;
endmodule
`default_nettype wire

[sv/msu_merge.sv]
// Merge stage: minimum over lanes, running maximum over samples.
`default_nettype none
module msu_merge #(
    parameter int NL = msu_pkg::LAYERS_DEF
) (
    input  logic                       i_clk,
    input  msu_pkg::t_merge_ctl        i_ctl,
    input  logic [msu_pkg::SIM_W-1:0]  i_sim [NL],
    output logic [msu_pkg::SIM_W-1:0]  o_best
);
    import msu_pkg::*;

    logic [SIM_W-1:0] w_min;
    logic [SIM_W-1:0] r_best;

    always_comb begin
        w_min = ONE_Q16;
        for (int l = 0; l < NL; l++) begin
            if (i_sim[l] < w_min) begin
                w_min = i_sim[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_best <= '0;
        end else if (i_ctl.vld && (w_min > r_best)) begin
            r_best <= w_min;
        end
    end

    assign o_best = r_best;
endmodule
`default_nettype wire

[sv/max_similarity_uncertainty.sv]
// Top level: max-similarity uncertainty block with sample store and running totals.
//
// Usage:
//   An item is taken at a clock edge with start high and busy low. i_req_type selects
//   query (0), load sample (1) or clear (2); type 3 is dropped without a result.
//   Each result shows on the o_ ports for one cycle with o_strobe high; the receiver
//   cannot stall, and running totals on the result are those after the item.
//   Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_idx (0..3 inverse
//   ranges, 4 factor mask, 5 threshold); write only while the block is idle.
// Timing:
//   Load and clear: result in the cycle after the accept, busy stays low.
//   Query on an active cell: one sample read per cycle from the store RAM, four
//   lanes compare all layers in parallel, then a merge stage; busy stays high
//   until the result is registered, so no new item is taken while a query runs.
//   Inactive cell or empty store: no scan; the done state registers the result.
// Reset:
//   Synchronous, active low: store empty, totals zero, registers at reset values.
`default_nettype none
module max_similarity_uncertainty #(
    parameter int LAYERS    = msu_pkg::LAYERS_DEF,
    parameter int SAMPLES   = msu_pkg::SAMPLES_DEF,
    parameter int MAX_CELLS = msu_pkg::MAX_CELLS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cfg_we,
    input  logic [msu_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [msu_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic [1:0]                          i_req_type,
    input  logic signed [msu_pkg::VAL_W-1:0]    i_layer_value_0,
    input  logic signed [msu_pkg::VAL_W-1:0]    i_layer_value_1,
    input  logic signed [msu_pkg::VAL_W-1:0]    i_layer_value_2,
    input  logic signed [msu_pkg::VAL_W-1:0]    i_layer_value_3,
    input  logic                                i_active,
    output logic                                o_strobe,
    output logic [1:0]                          o_status,
    output logic [msu_pkg::SIM_W-1:0]           o_uncertainty,
    output logic                                o_can_predict,
    output logic [msu_pkg::CNT_OUT_W-1:0]       o_predictable_count,
    output logic [msu_pkg::SUM_OUT_W-1:0]       o_uncertainty_sum
);
    import msu_pkg::*;

    localparam int    NL        = (LAYERS < FIELDS) ? LAYERS : FIELDS;
    localparam int    AW        = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int    CNTW      = $clog2(SAMPLES + 1);
    localparam int    PCW       = $clog2(MAX_CELLS + 1);
    localparam longint SUM_LIMIT = longint'(MAX_CELLS) * 65536;
    localparam int    SUMW      = $clog2(SUM_LIMIT + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic [AW-1:0]            r_addr;
    logic [CNTW-1:0]          r_count;
    logic                     r_v1;
    logic                     r_v2;
    logic                     r_v3;
    logic [INV_W-1:0]         r_inv [FIELDS];
    logic [MASK_W-1:0]        r_mask;
    logic [SIM_W-1:0]         r_thr;
    logic [PCW-1:0]           r_pred_total;
    logic [SUMW-1:0]          r_sum_total;
    logic                     r_strobe;
    logic [1:0]               r_status;
    logic [SIM_W-1:0]         r_unc;
    logic                     r_pred;
    logic signed [VAL_W-1:0]  r_cell [FIELDS];
    logic                     r_active;

    logic signed [VAL_W-1:0]  w_cell_in [FIELDS];
    logic                     w_acc;
    logic                     w_last;
    logic                     w_ram_we;
    logic [SAMPLE_W-1:0]      w_rdata;
    logic [SIM_W-1:0]         w_sim [NL];
    logic [SIM_W-1:0]         w_best;
    logic [SIM_W-1:0]         w_unc;
    logic                     w_pred;
    logic [SUMW:0]            w_sum_add;
    logic [SUMW-1:0]          w_sum_next;
    t_merge_ctl               w_mctl;
    logic [63:0]              w_pt_ext;
    logic [63:0]              w_sum_ext;

    assign w_cell_in[0] = i_layer_value_0;
    assign w_cell_in[1] = i_layer_value_1;
    assign w_cell_in[2] = i_layer_value_2;
    assign w_cell_in[3] = i_layer_value_3;

    assign busy     = (r_state != S_IDLE);
    assign w_acc    = start && !busy;
    assign w_last   = ((CNTW'(r_addr) + CNTW'(1)) == r_count);
    assign w_ram_we = w_acc && (i_req_type == REQ_LOAD) && i_active
                      && (r_count < CNTW'(SAMPLES));

    assign w_mctl.clr = w_acc && (i_req_type == REQ_QUERY);
    assign w_mctl.vld = r_v3;

    assign w_unc      = ONE_Q16 - w_best;
    assign w_pred     = r_active && (w_unc <= r_thr);
    assign w_sum_add  = (SUMW+1)'(r_sum_total) + (SUMW+1)'(w_unc);
    assign w_sum_next = (w_sum_add > (SUMW+1)'(SUM_LIMIT)) ? SUMW'(SUM_LIMIT)
                                                           : w_sum_add[SUMW-1:0];

    msu_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (SAMPLES),
        .ADDR_W(AW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata({i_layer_value_3, i_layer_value_2, i_layer_value_1, i_layer_value_0}),
        .i_re   (r_state == S_SCAN),
        .i_raddr(r_addr),
        .o_rdata(w_rdata)
    );

    for (genvar l = 0; l < NL; l++) begin : g_lane
        msu_lane u_lane (
            .i_clk    (i_clk),
            .i_cell   (r_cell[l]),
            .i_sample (w_rdata[l*VAL_W +: VAL_W]),
            .i_inv    (r_inv[l]),
            .i_eq_mode(r_mask[l]),
            .o_sim    (w_sim[l])
        );
    end

    msu_merge #(
        .NL(NL)
    ) u_merge (
        .i_clk (i_clk),
        .i_ctl (w_mctl),
        .i_sim (w_sim),
        .o_best(w_best)
    );

    always_ff @(posedge i_clk) begin
        if (w_acc && (i_req_type == REQ_QUERY)) begin
            r_cell   <= w_cell_in;
            r_active <= i_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_addr       <= '0;
            r_count      <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_inv        <= '{default: INV_RESET};
            r_mask       <= '0;
            r_thr        <= THR_RESET;
            r_pred_total <= '0;
            r_sum_total  <= '0;
            r_strobe     <= 1'b0;
            r_status     <= ST_QUERY;
            r_unc        <= '0;
            r_pred       <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_v1     <= (r_state == S_SCAN);
            r_v2     <= r_v1;
            r_v3     <= r_v2;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_INV0: r_inv[0] <= i_cfg_wdata;
                    CFG_INV1: r_inv[1] <= i_cfg_wdata;
                    CFG_INV2: r_inv[2] <= i_cfg_wdata;
                    CFG_INV3: r_inv[3] <= i_cfg_wdata;
                    CFG_MASK: r_mask   <= i_cfg_wdata[MASK_W-1:0];
                    CFG_THR:  r_thr    <= i_cfg_wdata[SIM_W-1:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        unique case (i_req_type)
                            REQ_QUERY: begin
                                r_addr <= '0;
                                if (i_active && (r_count != '0)) begin
                                    r_state <= S_SCAN;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            REQ_LOAD: begin
                                r_strobe <= 1'b1;
                                r_unc    <= '0;
                                r_pred   <= 1'b0;
                                if (r_count >= CNTW'(SAMPLES)) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_status <= ST_STORED;
                                    if (i_active) begin
                                        r_count <= r_count + CNTW'(1);
                                    end
                                end
                            end
                            REQ_CLEAR: begin
                                r_count      <= '0;
                                r_pred_total <= '0;
                                r_sum_total  <= '0;
                                r_strobe     <= 1'b1;
                                r_status     <= ST_CLEARED;
                                r_unc        <= '0;
                                r_pred       <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_DRAIN: begin
                    if (!r_v1 && !r_v2 && !r_v3) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_strobe <= 1'b1;
                    r_status <= ST_QUERY;
                    r_unc    <= w_unc;
                    r_pred   <= w_pred;
                    if (r_active) begin
                        r_sum_total <= w_sum_next;
                        if (w_pred && (r_pred_total < PCW'(MAX_CELLS))) begin
                            r_pred_total <= r_pred_total + PCW'(1);
                        end
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign w_pt_ext  = 64'(r_pred_total);
    assign w_sum_ext = 64'(r_sum_total);

    assign o_strobe            = r_strobe;
    assign o_status            = r_status;
    assign o_uncertainty       = r_unc;
    assign o_can_predict       = r_pred;
    assign o_predictable_count = w_pt_ext[CNT_OUT_W-1:0];
    assign o_uncertainty_sum   = w_sum_ext[SUM_OUT_W-1:0];
endmodule
`default_nettype wire

[sv/msu_checker.sv]
// Port-level checker for the max-similarity uncertainty block, with its bind.
`default_nettype none
`include "max_similarity_uncertainty_assert.svh"
module msu_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [1:0]                          i_req_type,
    input  logic                                o_strobe,
    input  logic [1:0]                          o_status,
    input  logic [msu_pkg::SIM_W-1:0]           o_uncertainty,
    input  logic                                o_can_predict,
    input  logic [msu_pkg::CNT_OUT_W-1:0]       o_predictable_count,
    input  logic [msu_pkg::SUM_OUT_W-1:0]       o_uncertainty_sum
);
    import msu_pkg::*;

    logic w_acc;
    assign w_acc = start && !busy;

    `MSU_ASSERT_SAME(a_unc_range, o_strobe, o_uncertainty <= ONE_Q16)
    `MSU_ASSERT_SAME(a_nonquery_zero, o_strobe && (o_status != ST_QUERY),
                     (o_uncertainty == '0) && !o_can_predict)
    `MSU_ASSERT_SAME(a_pred_on_query, o_strobe && o_can_predict, o_status == ST_QUERY)
    `MSU_ASSERT_NEXT(a_load_result, w_acc && (i_req_type == REQ_LOAD),
                     o_strobe && ((o_status == ST_STORED) || (o_status == ST_FULL)))
    `MSU_ASSERT_NEXT(a_clear_result, w_acc && (i_req_type == REQ_CLEAR),
                     o_strobe && (o_status == ST_CLEARED) && (o_predictable_count == '0)
                     && (o_uncertainty_sum == '0))
endmodule

bind max_similarity_uncertainty msu_checker u_msu_checker (.*);
`default_nettype wire

[verif/tb_max_similarity_uncertainty.sv]
// Testbench for max_similarity_uncertainty: random command stream, in-bench predictor, checks.
`timescale 1ns / 1ps
module tb_max_similarity_uncertainty;
    import msu_pkg::*;

    localparam int          STORE_DEPTH = SAMPLES_DEF;
    localparam int unsigned ONE         = 65536;
    localparam logic [63:0] CELL_CAP    = 64'(MAX_CELLS_DEF);
    localparam logic [63:0] SUM_CAP     = 64'(MAX_CELLS_DEF) * 64'd65536;
    localparam int          SETTLE      = 80;

    typedef logic [FIELDS-1:0][VAL_W-1:0] point_t;

    typedef struct packed {
        logic [1:0] kind;
        point_t     val;
        logic       act;
        logic       drain;
    } cell_item_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [SIM_W-1:0]     unc;
        logic                 pred;
        logic [CNT_OUT_W-1:0] cnt;
        logic [SUM_OUT_W-1:0] sum;
    } cell_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    logic [1:0] i_req_type = REQ_QUERY;
    logic signed [VAL_W-1:0] i_layer_value_0 = '0;
    logic signed [VAL_W-1:0] i_layer_value_1 = '0;
    logic signed [VAL_W-1:0] i_layer_value_2 = '0;
    logic signed [VAL_W-1:0] i_layer_value_3 = '0;
    logic i_active = 1'b0;
    logic o_strobe;
    logic [1:0] o_status;
    logic [SIM_W-1:0] o_uncertainty;
    logic o_can_predict;
    logic [CNT_OUT_W-1:0] o_predictable_count;
    logic [SUM_OUT_W-1:0] o_uncertainty_sum;

    max_similarity_uncertainty dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_req_type          (i_req_type),
        .i_layer_value_0     (i_layer_value_0),
        .i_layer_value_1     (i_layer_value_1),
        .i_layer_value_2     (i_layer_value_2),
        .i_layer_value_3     (i_layer_value_3),
        .i_active            (i_active),
        .o_strobe            (o_strobe),
        .o_status            (o_status),
        .o_uncertainty       (o_uncertainty),
        .o_can_predict       (o_can_predict),
        .o_predictable_count (o_predictable_count),
        .o_uncertainty_sum   (o_uncertainty_sum)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    cell_item_t   pending_items[$];
    cell_result_t expected_results[$];
    point_t       loaded_points[$];

    // predictor state
    point_t      sample_mem[STORE_DEPTH];
    int unsigned stored_cnt;
    logic [63:0] pred_total;
    logic [63:0] unc_total;
    logic [31:0] inv_range[FIELDS];
    logic [3:0]  factor_mask;
    logic [16:0] unc_limit;

    logic taken = 1'b0;
    int   sent = 0;
    int   errors = 0;
    int   n_accepted = 0;
    int   n_checked = 0;
    int   n_pred = 0;
    int   n_full = 0;
    int   n_phases = 0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $realtime, what);
        errors++;
    endtask

    function automatic bit predict_uncertainty(input cell_item_t it, output cell_result_t r);
        int unsigned best, sim, lsim, unc;
        int          d;
        logic [63:0] pen;
        r = '0;
        case (it.kind)
            REQ_CLEAR: begin
                stored_cnt = 0;
                pred_total = '0;
                unc_total  = '0;
                r.status   = ST_CLEARED;
            end
            REQ_LOAD: begin
                if (stored_cnt >= STORE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (it.act) begin
                        sample_mem[stored_cnt] = it.val;
                        stored_cnt++;
                    end
                    r.status = ST_STORED;
                end
            end
            REQ_QUERY: begin
                r.status = ST_QUERY;
                if (!it.act) begin
                    r.unc = ONE_Q16;
                end else begin
                    best = 0;
                    for (int s = 0; s < stored_cnt; s++) begin
                        sim = ONE;
                        for (int k = 0; k < FIELDS; k++) begin
                            if (factor_mask[k]) begin
                                lsim = (it.val[k] == sample_mem[s][k]) ? ONE : 0;
                            end else begin
                                d = int'($signed(it.val[k])) - int'($signed(sample_mem[s][k]));
                                if (d < 0)
                                    d = -d;
                                pen = (64'(d) * 64'(inv_range[k])) >> 16;
                                lsim = (pen >= 64'(ONE)) ? 0 : ONE - 32'(pen);
                            end
                            if (lsim < sim)
                                sim = lsim;
                        end
                        if (sim > best)
                            best = sim;
                    end
                    unc = ONE - best;
                    if (unc <= unc_limit) begin
                        r.pred = 1'b1;
                        if (pred_total < CELL_CAP)
                            pred_total++;
                    end
                    unc_total = unc_total + 64'(unc);
                    if (unc_total > SUM_CAP)
                        unc_total = SUM_CAP;
                    r.unc = unc[SIM_W-1:0];
                end
            end
            default: return 1'b0;
        endcase
        r.cnt = pred_total[CNT_OUT_W-1:0];
        r.sum = unc_total[SUM_OUT_W-1:0];
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : monitor
        cell_item_t   seen;
        cell_result_t got, want, fresh;
        if (!i_rst_n) begin
            stored_cnt  = 0;
            pred_total  = '0;
            unc_total   = '0;
            for (int k = 0; k < FIELDS; k++)
                inv_range[k] = INV_RESET;
            factor_mask = '0;
            unc_limit   = THR_RESET;
            taken <= 1'b0;
        end else begin
            if (o_strobe) begin
                got = '{o_status, o_uncertainty, o_can_predict, o_predictable_count,
                        o_uncertainty_sum};
                if (expected_results.size() == 0) begin
                    report_mismatch("result strobe with no item outstanding");
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  got.status, want.status));
                    if (got.unc !== want.unc)
                        report_mismatch($sformatf("uncertainty %0d, want %0d",
                                                  got.unc, want.unc));
                    if (got.pred !== want.pred)
                        report_mismatch($sformatf("can_predict %0b, want %0b",
                                                  got.pred, want.pred));
                    if (got.cnt !== want.cnt)
                        report_mismatch($sformatf("predictable_count %0d, want %0d",
                                                  got.cnt, want.cnt));
                    if (got.sum !== want.sum)
                        report_mismatch($sformatf("uncertainty_sum %0d, want %0d",
                                                  got.sum, want.sum));
                    n_checked++;
                    if (want.pred)
                        n_pred++;
                    if (want.status == ST_FULL)
                        n_full++;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx) inside
                    CFG_INV0, CFG_INV1, CFG_INV2, CFG_INV3:
                        inv_range[i_cfg_idx[1:0]] = i_cfg_wdata;
                    CFG_MASK: factor_mask = i_cfg_wdata[MASK_W-1:0];
                    CFG_THR:  unc_limit = i_cfg_wdata[SIM_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                seen.kind  = i_req_type;
                seen.val   = {i_layer_value_3, i_layer_value_2, i_layer_value_1,
                              i_layer_value_0};
                seen.act   = i_active;
                seen.drain = 1'b0;
                if (predict_uncertainty(seen, fresh))
                    expected_results.insert(expected_results.size(), fresh);
                n_accepted++;
            end
            taken <= start && !busy;
        end
    end

    always @(negedge i_clk) begin : driver
        cell_item_t nxt;
        logic       send;
        bit         quiet;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || taken) begin
            quiet = (sent >= 500 && sent < 800);
            send = (pending_items.size() != 0);
            if (send && !quiet && $urandom_range(0, 99) < 7)
                send = 1'b0;
            if (send && pending_items[0].drain && (expected_results.size() != 0 || busy))
                send = 1'b0;
            if (send) begin
                nxt = pending_items.pop_front();
                i_req_type      <= nxt.kind;
                i_layer_value_0 <= nxt.val[0];
                i_layer_value_1 <= nxt.val[1];
                i_layer_value_2 <= nxt.val[2];
                i_layer_value_3 <= nxt.val[3];
                i_active        <= nxt.act;
                sent++;
            end
            start <= send;
        end
    end

    function automatic void push_item(input logic [1:0] kind, input point_t v,
                                      input logic act, input logic hold);
        cell_item_t it;
        it.kind  = kind;
        it.val   = v;
        it.act   = act;
        it.drain = hold;
        pending_items.insert(pending_items.size(), it);
        if (kind == REQ_CLEAR)
            loaded_points.delete();
        else if (kind == REQ_LOAD && act && loaded_points.size() < STORE_DEPTH)
            loaded_points.insert(loaded_points.size(), v);
    endfunction

    function automatic logic [VAL_W-1:0] any_value();
        case ($urandom_range(0, 11))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic point_t any_point();
        point_t p;
        for (int k = 0; k < FIELDS; k++)
            p[k] = any_value();
        return p;
    endfunction

    // a stored point with some layers nudged
    function automatic point_t near_point();
        point_t p;
        int     m;
        p = loaded_points[$urandom_range(0, loaded_points.size() - 1)];
        for (int k = 0; k < FIELDS; k++) begin
            case ($urandom_range(0, 3))
                0: m = 0;
                1: m = 15;
                2: m = 255;
                default: m = 4095;
            endcase
            if ($urandom_range(0, 1))
                p[k] = p[k] + VAL_W'($urandom_range(0, 2 * m) - m);
        end
        return p;
    endfunction

    function automatic logic [31:0] pick_inv();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return INV_RESET;
            3: return 32'(64'h1_0000_0000 / 64'($urandom_range(2, 65535)));
            4: return 32'(64'h1_0000_0000 / 64'($urandom_range(16, 2000)));
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (pending_items.size() != 0 || start || expected_results.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
    endtask

    task automatic program_regs(input int phase);
        logic [31:0] inv[FIELDS];
        logic [3:0]  mask;
        logic [16:0] thr;
        for (int k = 0; k < FIELDS; k++)
            inv[k] = pick_inv();
        mask = 4'($urandom);
        thr  = 17'($urandom_range(0, 65536));
        case (phase)
            0: begin
                for (int k = 0; k < FIELDS; k++)
                    inv[k] = 32'hFFFF_FFFF;
                mask = 4'h0;
                thr  = 17'd0;
            end
            1: begin
                for (int k = 0; k < FIELDS; k++)
                    inv[k] = 32'h0;
                mask = 4'h0;
                thr  = ONE_Q16;
            end
            2: begin
                mask = 4'hF;
                thr  = ONE_Q16;
            end
            default: ;
        endcase
        write_reg(CFG_INV0, inv[0]);
        write_reg(CFG_INV1, inv[1]);
        write_reg(CFG_INV2, inv[2]);
        write_reg(CFG_INV3, inv[3]);
        write_reg(CFG_MASK, 32'(mask));
        write_reg(CFG_THR, 32'(thr));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic build_phase(input int n_random);
        int r;
        if ($urandom_range(0, 1))
            push_item(REQ_CLEAR, any_point(), 1'b1, 1'b0);
        repeat ($urandom_range(0, 72))
            push_item(REQ_LOAD, any_point(), $urandom_range(0, 9) != 0, 1'b0);
        repeat (n_random) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                push_item(REQ_CLEAR, any_point(), 1'(bit'($urandom)), 1'b0);
                repeat ($urandom_range(1, 20))
                    push_item(REQ_LOAD, any_point(), 1'b1, 1'b0);
            end else if (r < 18) begin
                push_item(REQ_LOAD, any_point(), $urandom_range(0, 9) != 0,
                          $urandom_range(0, 49) == 0);
            end else if (r < 20) begin
                push_item(2'd3, any_point(), 1'(bit'($urandom)), 1'b0);
            end else if (r < 30) begin
                push_item(REQ_QUERY, any_point(), $urandom_range(0, 1) != 0, 1'b0);
            end else if (loaded_points.size() != 0) begin
                push_item(REQ_QUERY, near_point(), $urandom_range(0, 19) != 0,
                          $urandom_range(0, 49) == 0);
            end else begin
                push_item(REQ_QUERY, any_point(), 1'b1, 1'b0);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings
        push_item(REQ_QUERY, '0, 1'b1, 1'b0);
        push_item(REQ_QUERY, '0, 1'b0, 1'b0);
        push_item(REQ_LOAD, {16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0}, 1'b0, 1'b0);
        push_item(REQ_LOAD, {16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000}, 1'b1, 1'b0);
        push_item(REQ_LOAD, {16'hAAAA, 16'h5555, 16'h8000, 16'h7FFF}, 1'b1, 1'b0);
        push_item(REQ_QUERY, {16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000}, 1'b1, 1'b0);
        push_item(REQ_QUERY, {16'hAAAA, 16'h5555, 16'h8000, 16'h7FFF}, 1'b1, 1'b0);
        push_item(REQ_QUERY, {16'hFFFF, 16'd3000, 16'h7FFF, 16'h8000}, 1'b1, 1'b0);
        push_item(REQ_QUERY, {16'hFFFF, 16'h0000, 16'h7FFF, 16'h7FFF}, 1'b1, 1'b0);
        push_item(REQ_QUERY, {16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF}, 1'b1, 1'b0);
        push_item(REQ_QUERY, {16'hAAAA, 16'h5555, 16'hC000, 16'h7FFF}, 1'b1, 1'b0);
        push_item(2'd3, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, 1'b0);
        push_item(REQ_QUERY, {16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000}, 1'b0, 1'b0);
        push_item(REQ_CLEAR, '0, 1'b0, 1'b1);
        push_item(REQ_QUERY, {16'hAAAA, 16'h5555, 16'h8000, 16'h7FFF}, 1'b1, 1'b0);
        push_item(REQ_LOAD, {16'h0001, 16'hFFFE, 16'h0100, 16'hFF00}, 1'b1, 1'b1);
        push_item(REQ_QUERY, {16'h0001, 16'hFFFE, 16'h0100, 16'hFF00}, 1'b1, 1'b0);
        push_item(REQ_QUERY, {16'h0001, 16'hFFFE, 16'h0100, 16'hFF01}, 1'b1, 1'b0);
        wait_idle();

        for (int p = 0; p < 10; p++) begin
            program_regs(p);
            build_phase(120);
            wait_idle();
            n_phases++;
        end

        $display("covered %0d items over %0d register settings plus reset settings",
                 n_accepted, n_phases);
        $display("checked %0d results: %0d predictable cells, %0d loads dropped on full store",
                 n_checked, n_pred, n_full);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout: %0d items still pending, %0d results outstanding",
                 pending_items.size(), expected_results.size());
        $display("end of test: mismatches");
        $finish;
    end
endmodule
